[hdl/page_frame_bitmap_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator assertion macros
// Concurrent checks with an implication or a next-cycle implication; empty
// when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PFBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pfba: same-cycle check failed");
`define PFBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pfba: next-cycle check failed");
`else
`define PFBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFBA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hdl/pfba_pkg.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Operation codes, field widths and word-level helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 32;
  localparam int IDX_W  = 15;
  localparam int FREE_W = 27;
  localparam int CFG_W  = 16;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam logic [CFG_W-1:0]  TOTAL_RESET = 16'd32768;
  localparam logic [WORD_W-1:0] WORD_ONES   = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  // Bits lo..hi inclusive set
  function automatic logic [WORD_W-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                  input logic [BIT_W-1:0] hi);
    span_mask = (WORD_ONES << lo) & (WORD_ONES >> (5'd31 - hi));
  endfunction

  // Position of the lowest clear bit; zero when none
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        p = BIT_W'(i);
      end
    end
    first_zero = p;
  endfunction

endpackage

`default_nettype wire

[hdl/pfba_in_if.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator request channel
// Valid/ready channel carrying one allocator operation per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfba_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfba_pkg::OP_W-1:0]     operation;
  logic [pfba_pkg::ADDR_W-1:0]   start_address;
  logic [pfba_pkg::ADDR_W-1:0]   range_bytes;
  logic [pfba_pkg::IDX_W-1:0]    block_index;

  modport source (output valid, operation, start_address, range_bytes, block_index,
                  input ready);
  modport sink   (input valid, operation, start_address, range_bytes, block_index,
                  output ready);
endinterface

`default_nettype wire

[hdl/pfba_out_if.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator result channel
// Valid/ready channel carrying one result word per operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfba_out_if;
  logic                          valid;
  logic                          ready;
  logic                          block_used;
  logic                          found;
  logic [pfba_pkg::FREE_W-1:0]   free_address;

  modport source (output valid, block_used, found, free_address, input ready);
  modport sink   (input valid, block_used, found, free_address, output ready);
endinterface

`default_nettype wire

[hdl/pfba_ram.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/page_frame_bitmap_allocator_core.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator core
// One used bit per physical block held in a word RAM; set/clear ranges, test
// one block and search for the first free block.
// ----------------------------------------------------------------------------
// After reset the core sweeps the bitmap RAM to all ones, one word a cycle,
// and takes no request until the sweep is done. One request is worked at a
// time; the bitmap RAM streams one word per cycle through a read-modify-write
// loop. An operation works through the bitmap words it touches: one for a
// test, the words a set or clear range spans below the managed count, and for
// a find-free the words up to the first word with a free bit (at most managed
// count / 32). A request whose range lies wholly past the managed count goes
// from S_CLAMP straight to S_DONE without a RAM read. The next request is
// taken while the last result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_frame_bitmap_allocator_core_assert.svh"

module page_frame_bitmap_allocator_core #(
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned MAX_BLOCKS  = 32768
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [pfba_pkg::CFG_W-1:0]   cfg_wdata,
  pfba_in_if.sink                           in_ch,
  pfba_out_if.source                        out_ch
);

  localparam int BSH       = $clog2(BLOCK_BYTES);
  localparam int MAP_WORDS = (MAX_BLOCKS + 31) / 32;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int SPAN_W    = 33 - BSH;
  localparam int CMP_W     = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;
  localparam int BW        = pfba_pkg::BIT_W;
  localparam int WW        = pfba_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SUM,
    S_CLAMP,
    S_RUN,
    S_DONE
  } state_t;

  // control
  state_t                     state_r, state_nxt;
  logic [WAW-1:0]             clr_ptr_r, clr_ptr_nxt;
  logic [pfba_pkg::CFG_W-1:0] total_r, total_nxt;
  logic [WAW-1:0]             iss_ptr_r, iss_ptr_nxt;
  logic                       iss_done_r, iss_done_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // payload
  pfba_pkg::op_t              op_r, op_nxt;
  logic [CMP_W-1:0]           beg_r, beg_nxt;
  logic [CMP_W-1:0]           cnt_r, cnt_nxt;
  logic [CMP_W-1:0]           end_r, end_nxt;
  logic [CNT_W-1:0]           last_r, last_nxt;
  logic [WAW-1:0]             first_w_r, first_w_nxt;
  logic [WAW-1:0]             end_w_r, end_w_nxt;
  logic [WAW-1:0]             rd_addr_r, rd_addr_nxt;
  logic                       res_used_r, res_used_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [pfba_pkg::FREE_W-1:0] res_addr_r, res_addr_nxt;
  logic                       out_used_r, out_used_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [pfba_pkg::FREE_W-1:0] out_addr_r, out_addr_nxt;

  // datapath
  logic [CNT_W-1:0]           limit;
  logic                       in_acc;
  logic                       out_load;
  logic [CMP_W-1:0]           start_blk, size_blk;
  logic                       start_frac, size_frac;
  logic [CMP_W-1:0]           beg_in, cnt_in;
  logic [CMP_W-1:0]           end_c, last_c;
  logic                       span_ok;
  logic [BW-1:0]              lo_bit, hi_bit;
  logic [WW-1:0]              wmask;
  logic [63:0]                free_full;

  // RAM port
  logic                       ram_we, ram_re;
  logic [WAW-1:0]             ram_waddr, ram_raddr;
  logic [WW-1:0]              ram_wdata, ram_rdata;

  pfba_ram #(
    .WIDTH (WW),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_used   = out_used_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.free_address = out_addr_r;
  assign out_load            = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // managed block count
  always_comb begin
    if ({16'd0, total_r} >= 32'(MAX_BLOCKS)) begin
      limit = CNT_W'(MAX_BLOCKS);
    end else begin
      limit = CNT_W'(total_r);
    end
  end

  // request decode: first block and block count
  assign start_blk  = CMP_W'(in_ch.start_address >> BSH);
  assign size_blk   = CMP_W'(in_ch.range_bytes >> BSH);
  assign start_frac = |in_ch.start_address[BSH-1:0];
  assign size_frac  = |in_ch.range_bytes[BSH-1:0];

  always_comb begin
    unique case (pfba_pkg::op_t'(in_ch.operation))
      pfba_pkg::OP_SET: begin
        beg_in = start_blk;
        cnt_in = size_blk + CMP_W'(size_frac);
      end
      pfba_pkg::OP_CLEAR: begin
        beg_in = start_blk + CMP_W'(start_frac);
        cnt_in = size_blk;
      end
      pfba_pkg::OP_TEST: begin
        beg_in = CMP_W'(in_ch.block_index);
        cnt_in = CMP_W'(1'b1);
      end
      default: begin
        // find-free covers whole words below the managed count
        beg_in = '0;
        cnt_in = CMP_W'({limit[CNT_W-1:5], 5'd0});
      end
    endcase
  end

  // clamp the span to the managed count
  assign end_c   = (end_r > CMP_W'(limit)) ? CMP_W'(limit) : end_r;
  assign span_ok = beg_r < end_c;
  assign last_c  = end_c - CMP_W'(1'b1);

  // word mask for the word in writeback
  assign lo_bit    = (rd_addr_r == first_w_r) ? beg_r[BW-1:0] : '0;
  assign hi_bit    = (rd_addr_r == end_w_r) ? last_r[BW-1:0] : BW'(WW - 1);
  assign wmask     = pfba_pkg::span_mask(lo_bit, hi_bit);
  assign free_full = 64'({rd_addr_r, pfba_pkg::first_zero(ram_rdata)}) << BSH;

  always_comb begin
    state_nxt     = state_r;
    clr_ptr_nxt   = clr_ptr_r;
    total_nxt     = cfg_we ? cfg_wdata : total_r;
    iss_ptr_nxt   = iss_ptr_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    op_nxt        = op_r;
    beg_nxt       = beg_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    first_w_nxt   = first_w_r;
    end_w_nxt     = end_w_r;
    rd_addr_nxt   = rd_addr_r;
    res_used_nxt  = res_used_r;
    res_found_nxt = res_found_r;
    res_addr_nxt  = res_addr_r;
    out_used_nxt  = out_used_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;

    ram_we    = 1'b0;
    ram_waddr = rd_addr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = iss_ptr_r;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_r;
        ram_wdata = pfba_pkg::WORD_ONES;
        if (clr_ptr_r == WAW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + WAW'(1'b1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = pfba_pkg::op_t'(in_ch.operation);
          beg_nxt   = beg_in;
          cnt_nxt   = cnt_in;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        end_nxt   = beg_r + cnt_r;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        res_used_nxt  = 1'b0;
        res_found_nxt = 1'b0;
        res_addr_nxt  = '0;
        last_nxt      = CNT_W'(last_c);
        first_w_nxt   = WAW'(beg_r >> 5);
        end_w_nxt     = WAW'(last_c >> 5);
        iss_ptr_nxt   = WAW'(beg_r >> 5);
        iss_done_nxt  = 1'b0;
        if (span_ok) begin
          state_nxt = S_RUN;
        end else begin
          // nothing in range: a test past the count reads as used
          res_used_nxt = (op_r == pfba_pkg::OP_TEST);
          state_nxt    = S_DONE;
        end
      end
      S_RUN: begin
        // issue the next word read
        if (!iss_done_r) begin
          ram_re      = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = iss_ptr_r;
          if (iss_ptr_r == end_w_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_ptr_nxt = iss_ptr_r + WAW'(1'b1);
          end
        end
        // test, search, or modify and write back the word read last cycle
        if (rd_vld_r) begin
          unique case (op_r)
            pfba_pkg::OP_SET: begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | wmask;
              if (rd_addr_r == end_w_r) begin
                state_nxt = S_DONE;
              end
            end
            pfba_pkg::OP_CLEAR: begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~wmask;
              if (rd_addr_r == end_w_r) begin
                state_nxt = S_DONE;
              end
            end
            pfba_pkg::OP_TEST: begin
              res_used_nxt = ram_rdata[beg_r[BW-1:0]];
              state_nxt    = S_DONE;
            end
            default: begin
              if (ram_rdata != pfba_pkg::WORD_ONES) begin
                res_found_nxt = 1'b1;
                res_addr_nxt  = free_full[pfba_pkg::FREE_W-1:0];
                state_nxt     = S_DONE;
              end else if (rd_addr_r == end_w_r) begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
        if (state_nxt != S_RUN) begin
          rd_vld_nxt = 1'b0;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_used_nxt  = res_used_r;
          out_found_nxt = res_found_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_ptr_r   <= '0;
      total_r     <= pfba_pkg::TOTAL_RESET;
      iss_ptr_r   <= '0;
      iss_done_r  <= 1'b1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_used_r  <= 1'b0;
      out_found_r <= 1'b0;
      out_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      total_r     <= total_nxt;
      iss_ptr_r   <= iss_ptr_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_used_r  <= out_used_nxt;
      out_found_r <= out_found_nxt;
      out_addr_r  <= out_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    beg_r       <= beg_nxt;
    cnt_r       <= cnt_nxt;
    end_r       <= end_nxt;
    last_r      <= last_nxt;
    first_w_r   <= first_w_nxt;
    end_w_r     <= end_w_nxt;
    rd_addr_r   <= rd_addr_nxt;
    res_used_r  <= res_used_nxt;
    res_found_r <= res_found_nxt;
    res_addr_r  <= res_addr_nxt;
  end

  `PFBA_ASSERT_IMP(a_no_write_on_accept, clk, rst_n, in_acc, !ram_we)
  `PFBA_ASSERT_IMP(a_rw_distinct, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
  `PFBA_ASSERT_IMP(a_write_in_span, clk, rst_n, (state_r == S_RUN) && ram_we,
                   (ram_waddr >= first_w_r) && (ram_waddr <= end_w_r))
  `PFBA_ASSERT_NXT(a_done_loads, clk, rst_n, (state_r == S_DONE) && !out_valid_r, out_valid_r && (state_r == S_IDLE))

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// Page frame bitmap allocator core testbench
// Walks a directed table over reset state, range edges, unaligned clears and
// partial words, then random request phases under several block counts. Each
// result word is compared with the table or a local bitmap predictor, while
// both channel sides idle at random and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned BLOCK_SHIFT = 12;
  localparam int unsigned MAP_LIMIT   = 32768;
  localparam int unsigned MAP_WORDS   = MAP_LIMIT / pfba_pkg::WORD_W;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 13;

  typedef struct packed {
    pfba_pkg::op_t                   op;
    logic [pfba_pkg::ADDR_W-1:0]     start;
    logic [pfba_pkg::ADDR_W-1:0]     len;
    logic [pfba_pkg::IDX_W-1:0]      idx;
  } page_req_t;

  typedef struct packed {
    logic                            block_used;
    logic                            found;
    logic [pfba_pkg::FREE_W-1:0]     free_address;
  } alloc_result_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [pfba_pkg::CFG_W-1:0]      blocks;
    page_req_t                       req;
    bit                              typed;
    alloc_result_t                   want;
  } plan_row_t;

  localparam alloc_result_t ZERO = '0;
  localparam alloc_result_t USED = '{1'b1, 1'b0, 27'h0};

  // Typed results are the ones visible at a glance; the rest go to the predictor
  plan_row_t directed_plan [26] = '{
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd0}, 1'b1, USED},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd32767}, 1'b1, USED},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0, 32'h0, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_CLEAR, 32'h0, 32'h0004_0000, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b1,
      '{1'b0, 1'b1, 27'h0}},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0, 32'h1, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b1,
      '{1'b0, 1'b1, 27'h000_1000}},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0000_1000, 32'h0000_4000, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_CLEAR, 32'h0000_0001, 32'h0000_2FFF, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_CLEAR, 32'h07FF_E000, 32'hFFFF_FFFF, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd32767}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0, 32'hFFFF_FFFF, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b1, ZERO},
    '{ROW_CFG,  16'd40, '{pfba_pkg::OP_SET,   32'h0, 32'h0, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_CLEAR, 32'h0, 32'hFFFF_FFFF, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0, 32'h0002_0000, 15'd0}, 1'b0, ZERO},
    // blocks 32..39 are free but sit in a partial word
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_FIND,  32'h0, 32'h0, 15'd0}, 1'b1, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd39}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd40}, 1'b1, USED},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd32767}, 1'b1, USED},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_SET,   32'h0002_0FFF, 32'h1, 15'd0}, 1'b0, ZERO},
    '{ROW_WORD, 16'd0,  '{pfba_pkg::OP_TEST,  32'h0, 32'h0, 15'd32}, 1'b0, ZERO}
  };

  localparam logic [pfba_pkg::CFG_W-1:0] PHASE_BLOCKS [PHASES] = '{
    16'd0, 16'd1, 16'd31, 16'd32, 16'd33, 16'd300, 16'd97, 16'd1024,
    16'd2000, 16'd65535, 16'd4500, 16'd32768, 16'd160
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pfba_pkg::CFG_W-1:0] cfg_wdata;

  pfba_in_if  in_ch ();
  pfba_out_if out_ch ();

  page_frame_bitmap_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state
  logic [pfba_pkg::WORD_W-1:0] frame_map [MAP_WORDS];
  logic [pfba_pkg::CFG_W-1:0]  block_limit;

  alloc_result_t expected_results [$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  bit            no_idle = 1'b0;
  bit            long_hold_due = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned managed_blocks();
    return (block_limit > MAP_LIMIT) ? MAP_LIMIT : block_limit;
  endfunction

  function automatic void paint_span(longint unsigned first, longint unsigned count,
                                     bit value);
    longint unsigned limit;
    longint unsigned stop;
    limit = managed_blocks();
    if (first >= limit) return;
    stop = first + count;
    if (stop > limit) stop = limit;
    for (longint unsigned b = first; b < stop; b++) begin
      frame_map[b >> 5][b % 32] = value;
    end
  endfunction

  function automatic alloc_result_t predict_outcome(page_req_t req);
    alloc_result_t   res;
    longint unsigned first;
    longint unsigned words;
    int unsigned     p;
    res = '0;
    case (req.op)
      pfba_pkg::OP_SET: begin
        paint_span(req.start >> BLOCK_SHIFT,
                   (longint'(req.len) + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT, 1'b1);
      end
      pfba_pkg::OP_CLEAR: begin
        // unaligned start skips the partly covered block
        first = req.start >> BLOCK_SHIFT;
        if (req.start[BLOCK_SHIFT-1:0] != '0) first++;
        paint_span(first, req.len >> BLOCK_SHIFT, 1'b0);
      end
      pfba_pkg::OP_TEST: begin
        if (req.idx >= managed_blocks()) res.block_used = 1'b1;
        else res.block_used = frame_map[req.idx >> 5][req.idx % 32];
      end
      default: begin
        words = managed_blocks() / pfba_pkg::WORD_W;
        for (longint unsigned w = 0; w < words && !res.found; w++) begin
          if (frame_map[w] != pfba_pkg::WORD_ONES) begin
            p = 0;
            while (frame_map[w][p]) p++;
            res.found = 1'b1;
            res.free_address = pfba_pkg::FREE_W'(((w * pfba_pkg::WORD_W) + p) << BLOCK_SHIFT);
          end
        end
      end
    endcase
    return res;
  endfunction

  // Entered and left just after a falling edge
  task automatic offer_word(page_req_t req, bit typed, alloc_result_t want);
    int unsigned   gap;
    alloc_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= req.op;
    in_ch.start_address <= req.start;
    in_ch.range_bytes   <= req.len;
    in_ch.block_index   <= req.idx;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_outcome(req);
    expected_results.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic write_total(logic [pfba_pkg::CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    block_limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side
  initial begin
    alloc_result_t want;
    int unsigned   stall;
    int unsigned   held;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 14);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none pending: used=%0b found=%0b addr=%h",
                 $time, out_ch.block_used, out_ch.found, out_ch.free_address);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (want.block_used !== out_ch.block_used) begin
          $display("%0t: block_used expected %0b actual %0b",
                   $time, want.block_used, out_ch.block_used);
          fail_count++;
        end
        if (want.found !== out_ch.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_ch.found);
          fail_count++;
        end
        if (want.free_address !== out_ch.free_address) begin
          $display("%0t: free_address expected %h actual %h",
                   $time, want.free_address, out_ch.free_address);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Request side and phase control
  initial begin
    page_req_t       req;
    longint unsigned span;
    longint unsigned first;
    int unsigned     quota;
    int unsigned     counted;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = pfba_pkg::OP_SET;
    in_ch.start_address = '0;
    in_ch.range_bytes   = '0;
    in_ch.block_index   = '0;
    block_limit         = pfba_pkg::TOTAL_RESET;
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = pfba_pkg::WORD_ONES;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) write_total(directed_plan[r].blocks);
      else offer_word(directed_plan[r].req, directed_plan[r].typed, directed_plan[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_total(PHASE_BLOCKS[ph]);
      no_idle = (ph % 4 == 3);
      if (ph == 5) long_hold_due = 1'b1;
      quota = (PHASE_BLOCKS[ph] <= 1) ? 40 : 130;
      counted = 0;
      while (counted < quota) begin
        span = managed_blocks() + 40;
        req.op = pfba_pkg::op_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) req.start = $urandom();
        else req.start = pfba_pkg::ADDR_W'(($urandom_range(0, span) << BLOCK_SHIFT)
                                 | ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0));
        case ($urandom_range(0, 19))
          0:       req.len = $urandom();
          1:       req.len = 32'hFFFF_FFFF;
          default: req.len = ($urandom_range(0, 70) << BLOCK_SHIFT)
                             | ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
        endcase
        if ($urandom_range(0, 9) == 0) req.idx = pfba_pkg::IDX_W'($urandom());
        else req.idx = pfba_pkg::IDX_W'($urandom_range(0, (span > 32767) ? 32767 : span));
        // ranges wholly past the managed count do not count toward the quota
        first = req.start >> BLOCK_SHIFT;
        if (req.op == pfba_pkg::OP_CLEAR && req.start[BLOCK_SHIFT-1:0] != '0) first++;
        if (!((req.op == pfba_pkg::OP_SET || req.op == pfba_pkg::OP_CLEAR) &&
              first >= managed_blocks()))
          counted++;
        offer_word(req, 1'b0, ZERO);
      end
    end

    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/pfba_pkg.sv
hdl/pfba_in_if.sv
hdl/pfba_out_if.sv
hdl/pfba_ram.sv
hdl/page_frame_bitmap_allocator_core.sv
test/tb.sv
